@@ src/svt_pkg.sv @@
// ----------------------------------------------------------------------------
// svt_pkg: shared types and constants of the sparse vector table
// Operation codes, register indexes, default sizes and the result record.
// ----------------------------------------------------------------------------
package svt_pkg;

  localparam int unsigned DefCapacity = 1024;
  localparam int unsigned DefFracBits = 16;

  localparam int unsigned KeyW  = 32;
  localparam int unsigned ValW  = 32;
  localparam int unsigned PosW  = 10;
  localparam int unsigned CntW  = 11;
  localparam int unsigned ThrW  = 31;
  localparam int unsigned CfgAw = 1;

  // operation codes
  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_ADD   = 3'd1,
    OP_QUERY = 3'd2,
    OP_SCALE = 3'd3,
    OP_PRUNE = 3'd4,
    OP_READ  = 3'd5
  } op_e;

  // register indexes
  localparam logic [CfgAw-1:0] REG_MERGE = 1'd0;
  localparam logic [CfgAw-1:0] REG_THR   = 1'd1;

  // merge policies
  localparam logic [1:0] MERGE_ADD  = 2'd1;
  localparam logic [1:0] MERGE_REPL = 2'd2;

  // one result record
  typedef struct packed {
    logic signed [ValW-1:0] result_value;
    logic [KeyW-1:0]        result_key;
    logic                   hit;
    logic                   dropped;
    logic                   saturated;
    logic [CntW-1:0]        entry_count;
  } result_t;

endpackage

@@ src/svt_scale.sv @@
// ----------------------------------------------------------------------------
// svt_scale: registered fixed point multiply with floor shift and clamp
// The 32x32 product is registered before the shift; the shift and clamp are combinational.
// ----------------------------------------------------------------------------
module svt_scale #(
  parameter int unsigned FracBits = svt_pkg::DefFracBits
) (
  input  logic                              clk_i,
  input  logic signed [svt_pkg::ValW-1:0]   a_i,
  input  logic signed [svt_pkg::ValW-1:0]   b_i,
  output logic signed [svt_pkg::ValW-1:0]   y_o,
  output logic                              sat_o
);
  import svt_pkg::*;

  logic signed [2*ValW-1:0] prod_q;
  logic signed [2*ValW-1:0] shf;

  // product register
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  // arithmetic shift is a floor shift; then clamp
  always_comb begin
    shf   = prod_q >>> FracBits;
    sat_o = 1'b0;
    y_o   = shf[ValW-1:0];
    if (shf > $signed({{(ValW+1){1'b0}}, {(ValW-1){1'b1}}})) begin
      sat_o = 1'b1;
      y_o   = {1'b0, {(ValW-1){1'b1}}};
    end else if (shf < $signed({{(ValW+1){1'b1}}, {(ValW-1){1'b0}}})) begin
      sat_o = 1'b1;
      y_o   = {1'b1, {(ValW-1){1'b0}}};
    end
  end
endmodule

@@ src/sparse_vector_table.sv @@
// ----------------------------------------------------------------------------
// sparse_vector_table: sparse vector held as (key, value) pairs
// Sequencer over one key memory and one value memory.
// ----------------------------------------------------------------------------
// One operation at a time. Add, query, scale and prune walk the occupied
// slots through the registered memory read port: one slot per cycle for
// add/query/prune, while scale reads each slot, multiplies it in a
// register and writes it back. The result waits in an output register;
// the next item may be taken and worked on while it waits, and that
// operation holds before its result until the register has been emptied.
// The memories need no clearing after reset.
module sparse_vector_table #(
  parameter int unsigned Capacity = svt_pkg::DefCapacity,
  parameter int unsigned FracBits = svt_pkg::DefFracBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tdata: mode[2:0], key[34:3], value[66:35], position[76:67], pad to 80
  input  logic [79:0]                    s_axis_tdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: result_value[31:0], result_key[63:32], hit[64], dropped[65],
  //        saturated[66], entry_count[77:67], pad to 80
  output logic [79:0]                    m_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [svt_pkg::CfgAw-1:0]      cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);
  import svt_pkg::*;

  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned NW = $clog2(Capacity + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_WAIT  = 6'b000100,
    ST_MUL   = 6'b001000,
    ST_DONE  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [KeyW-1:0] key_mem [Capacity];
  logic [ValW-1:0] val_mem [Capacity];

  logic [1:0]     merge_q;
  logic [ThrW-1:0] thr_q;
  logic [NW-1:0]  cnt_q, cnt_d;
  logic [2:0]     mode_q;
  logic [KeyW-1:0] key_q;
  logic signed [ValW-1:0] val_q;
  logic [PosW-1:0] pos_q;
  logic [NW-1:0]  rd_q, rd_d;     // next slot to read
  logic [NW-1:0]  cur_q, cur_d;   // slot whose data is on the read port
  logic [NW-1:0]  wr_q, wr_d;     // prune write pointer
  logic           rv_q, rv_d;     // read data valid
  logic signed [ValW+NW:0] acc_q, acc_d;
  logic           hit_q, hit_d, sat_q, sat_d, drop_q, drop_d;
  logic [NW-1:0]  fpos_q, fpos_d; // first match
  logic [KeyW-1:0] rkey_q, rkey_d;
  logic signed [ValW-1:0] rval_q, rval_d;
  result_t        res_q, res_d;
  logic           ovld_q;

  logic           re;
  logic [AW-1:0]  ra;
  logic [KeyW-1:0] kr_q;
  logic [ValW-1:0] vr_q;
  logic           kwe, vwe;
  logic [AW-1:0]  ka, va;
  logic [KeyW-1:0] kw;
  logic [ValW-1:0] vw;

  logic dup, in_acc;
  logic signed [ValW-1:0] mul_y, sum_y;
  logic mul_sat, sum_sat;
  logic signed [ValW:0] sum_w;
  logic [ValW:0] mag;

  assign dup    = (merge_q != MERGE_ADD) && (merge_q != MERGE_REPL);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {2'b00, res_q.entry_count, res_q.saturated, res_q.dropped,
                          res_q.hit, res_q.result_key, res_q.result_value};

  // memories, registered read
  always_ff @(posedge clk_i) begin
    if (kwe) key_mem[ka] <= kw;
    if (vwe) val_mem[va] <= vw;
    if (re) begin
      kr_q <= key_mem[ra];
      vr_q <= val_mem[ra];
    end
  end

  svt_scale #(.FracBits(FracBits)) u_scale (
    .clk_i (clk_i),
    .a_i   ($signed(vr_q)),
    .b_i   (val_q),
    .y_o   (mul_y),
    .sat_o (mul_sat)
  );

  // merge add with clamp, and magnitude
  always_comb begin
    sum_w   = $signed({vr_q[ValW-1], vr_q}) + $signed({val_q[ValW-1], val_q});
    sum_sat = sum_w[ValW] != sum_w[ValW-1];
    sum_y   = sum_sat ? {sum_w[ValW], {(ValW-1){~sum_w[ValW]}}} : sum_w[ValW-1:0];
    mag     = vr_q[ValW-1] ? ({1'b0, ~vr_q} + 1'b1) : {1'b0, vr_q};
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q; rd_d = rd_q; cur_d = cur_q; wr_d = wr_q; rv_d = 1'b0;
    acc_d = acc_q; hit_d = hit_q; sat_d = sat_q; drop_d = drop_q;
    fpos_d = fpos_q; rkey_d = rkey_q; rval_d = rval_q;
    res_d = res_q;
    re = 1'b0; ra = rd_q[AW-1:0];
    kwe = 1'b0; vwe = 1'b0; ka = wr_q[AW-1:0]; va = wr_q[AW-1:0];
    kw = kr_q; vw = vr_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          rd_d = '0; wr_d = '0; acc_d = '0; hit_d = 1'b0; sat_d = 1'b0;
          drop_d = 1'b0; rkey_d = '0; rval_d = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // issue reads; evaluate the slot on the read port
        if (rv_q) begin
          case (mode_q)
            OP_ADD, OP_QUERY: begin
              if (kr_q == key_q) begin
                if (mode_q == OP_QUERY && dup)
                  acc_d = acc_q + {{(NW+1){vr_q[ValW-1]}}, vr_q};
                else if (!hit_q) begin
                  fpos_d = cur_q; rval_d = $signed(vr_q);
                end
                hit_d = 1'b1;
              end
            end
            OP_PRUNE: begin
              if (mag >= {2'b00, thr_q}) begin
                kwe = 1'b1; vwe = 1'b1; wr_d = wr_q + 1'b1;
              end
            end
            default: ;
          endcase
        end
        if (mode_q == OP_SCALE && rv_q) begin
          state_d = ST_MUL;
        end else if (rd_q < cnt_q && mode_q != OP_CLEAR && mode_q != OP_READ
                     && mode_q <= OP_PRUNE) begin
          re = 1'b1; rv_d = 1'b1; cur_d = rd_q; rd_d = rd_q + 1'b1;
        end else if (!rv_q) begin
          state_d = ST_DONE;
          if (mode_q == OP_READ) begin
            re = 1'b1; ra = pos_q[AW-1:0]; state_d = ST_WAIT;
          end
        end
      end
      ST_MUL: begin
        // product registered last cycle; write back
        vwe = 1'b1; va = cur_q[AW-1:0]; vw = mul_y;
        if (mul_sat) sat_d = 1'b1;
        state_d = ST_SCAN;
      end
      ST_WAIT: begin
        if ({{(32-NW){1'b0}}, cnt_q} > {{(32-PosW){1'b0}}, pos_q}) begin
          hit_d = 1'b1; rkey_d = kr_q; rval_d = $signed(vr_q);
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // hold until the result register is free
        if (!ovld_q || m_axis_tready) begin
          res_d = '0;
          case (mode_q)
            OP_CLEAR: cnt_d = '0;
            OP_ADD: begin
              if (!dup && hit_q) begin
                re = 1'b1; ra = fpos_q[AW-1:0]; state_d = ST_OUT;
              end else if (cnt_q >= NW'(Capacity)) begin
                drop_d = 1'b1;
              end else begin
                kwe = 1'b1; vwe = 1'b1; ka = cnt_q[AW-1:0]; va = cnt_q[AW-1:0];
                kw = key_q; vw = val_q; cnt_d = cnt_q + 1'b1;
              end
            end
            OP_QUERY: begin
              if (dup) begin
                if (acc_q > $signed({{(NW+2){1'b0}}, {(ValW-1){1'b1}}})) begin
                  rval_d = {1'b0, {(ValW-1){1'b1}}}; sat_d = 1'b1;
                end else if (acc_q < $signed({{(NW+2){1'b1}}, {(ValW-1){1'b0}}})) begin
                  rval_d = {1'b1, {(ValW-1){1'b0}}}; sat_d = 1'b1;
                end else rval_d = acc_q[ValW-1:0];
              end
            end
            OP_PRUNE: cnt_d = wr_q;
            default: ;
          endcase
          if (state_d == ST_DONE) state_d = ST_OUT;
          if (!(mode_q == OP_ADD && !dup && hit_q)) begin
            state_d = ST_IDLE;
            res_d.result_value = (mode_q == OP_QUERY || mode_q == OP_READ) ? rval_d : '0;
            res_d.result_key   = (mode_q == OP_READ) ? rkey_d : '0;
            res_d.hit          = (mode_q == OP_QUERY || mode_q == OP_READ) ? hit_d : 1'b0;
            res_d.dropped      = drop_d;
            res_d.saturated    = sat_d;
            res_d.entry_count  = CntW'(cnt_d);
          end
        end
      end
      ST_OUT: begin
        // merge write back into the first match
        vwe = 1'b1; va = fpos_q[AW-1:0];
        vw  = (merge_q == MERGE_ADD) ? sum_y : val_q;
        res_d = '0;
        res_d.saturated   = (merge_q == MERGE_ADD) && sum_sat;
        res_d.entry_count = CntW'(cnt_q);
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ST_OUT reads fpos in ST_DONE, data arrives next cycle in vr_q
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      merge_q <= '0;
      thr_q   <= '0;
      ovld_q  <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rv_q    <= rv_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_MERGE) merge_q <= cfg_data_i[1:0];
        if (cfg_index_i == REG_THR)   thr_q   <= cfg_data_i[ThrW-1:0];
      end
      if (m_axis_tvalid && m_axis_tready) ovld_q <= 1'b0;
      if ((state_q == ST_DONE || state_q == ST_OUT) && state_d == ST_IDLE) ovld_q <= 1'b1;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    rd_q <= rd_d; cur_q <= cur_d; wr_q <= wr_d;
    acc_q <= acc_d; hit_q <= hit_d; sat_q <= sat_d; drop_q <= drop_d;
    fpos_q <= fpos_d; rkey_q <= rkey_d; rval_q <= rval_d; res_q <= res_d;
    if (in_acc) begin
      mode_q <= s_axis_tdata[2:0];
      key_q  <= s_axis_tdata[34:3];
      val_q  <= $signed(s_axis_tdata[66:35]);
      pos_q  <= s_axis_tdata[76:67];
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(Capacity)) else $error("entry count beyond capacity");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("pending result changed");
  a_out_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovld_q) |-> $past(state_q == ST_DONE || state_q == ST_OUT))
    else $error("result without finished operation");
  a_prune_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> wr_q <= rd_q) else $error("prune writes ahead of reads");
`endif
endmodule
